// ===== hw/rtl/msi_pkg.sv =====
// package for the sigmoid mlp inference core: types, codes, sigmoid table
// no dependencies
package msi_pkg;

  localparam int MAX_NEURONS = 16;
  localparam int NRN_W       = $clog2(MAX_NEURONS);
  localparam int NCNT_W      = $clog2(MAX_NEURONS + 1);
  localparam int SIG_DEPTH   = 256;
  localparam int SIG_IDX_W   = $clog2(SIG_DEPTH);
  localparam int COEFF_W     = 16;
  localparam int DATA_W      = 32;
  localparam int PROD_W      = COEFF_W + DATA_W;
  localparam int SUM_W       = PROD_W + 2;
  localparam int ACT_W       = 17;
  localparam int ACC_W       = COEFF_W + ACT_W + NRN_W + 3;
  localparam int PADDR_W     = 3;

  localparam logic [1:0] CMD_PREDICT  = 2'd0;
  localparam logic [1:0] CMD_LOAD_W   = 2'd1;
  localparam logic [1:0] CMD_LOAD_B   = 2'd2;
  localparam logic [1:0] CMD_LOAD_OW  = 2'd3;
  localparam logic [1:0] NUM_SLOTS    = 2'd3;

  localparam logic REG_ACTIVE = 1'b0;
  localparam logic REG_BIAS   = 1'b1;

  typedef enum logic [1:0] {
    OP_PREDICT,
    OP_LOAD_W,
    OP_LOAD_B,
    OP_LOAD_OW
  } op_t;

  typedef struct packed {
    op_t                        op;
    logic [NRN_W-1:0]           neuron;
    logic [1:0]                 slot;
    logic signed [COEFF_W-1:0]  coeff;
    logic signed [DATA_W-1:0]   x0;
    logic signed [DATA_W-1:0]   x1;
    logic signed [DATA_W-1:0]   x2;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } q_wr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef logic [ACT_W-1:0] sig_tab_t [SIG_DEPTH];

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  // shift and subtract quotient, used only while building the table
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] dnm);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, dnm}) begin
        r    = r - {1'b0, dnm};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic sig_tab_t build_sig_table();
    sig_tab_t    tab;
    longint      m;
    logic        neg;
    logic [63:0] mag;
    logic [63:0] a;
    logic [63:0] g;
    logic [63:0] term;
    longint      sum;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] pos;
    for (int i = 0; i < SIG_DEPTH; i++) begin
      m    = 2 * longint'(i) + 1 - longint'(SIG_DEPTH);
      neg  = m < 0;
      mag  = neg ? 64'(-m) : 64'(m);
      a    = (mag * (64'd8 * Q30_ONE)) >> SIG_IDX_W;
      g    = a >> 3;
      term = Q30_ONE;
      sum  = longint'(Q30_ONE);
      for (int k = 1; k <= 16; k++) begin
        term = udiv64((term * g) >> 30, 64'(k));
        if ((k & 1) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      e = (sum < 0) ? 64'd0 : 64'(sum);
      for (int k = 0; k < 3; k++) begin
        e = (e * e) >> 30;
      end
      den = Q30_ONE + e;
      pos = udiv64((64'd1 << 46) + (den >> 1), den);
      tab[i] = neg ? ACT_W'(64'd65536 - pos) : ACT_W'(pos);
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage

// ===== hw/rtl/msi_if.sv =====
// channel interfaces for the sigmoid mlp inference core
// depends on msi_pkg
interface msi_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           command;
  logic [msi_pkg::NRN_W-1:0]            neuron_index;
  logic [1:0]                           input_slot;
  logic signed [msi_pkg::COEFF_W-1:0]   coeff_value;
  logic signed [msi_pkg::DATA_W-1:0]    amplitude_in;
  logic signed [msi_pkg::DATA_W-1:0]    period_in;
  logic signed [msi_pkg::DATA_W-1:0]    time_in;
  modport source (output valid, command, neuron_index, input_slot, coeff_value,
                  amplitude_in, period_in, time_in, input ready);
  modport sink (input valid, command, neuron_index, input_slot, coeff_value,
                amplitude_in, period_in, time_in, output ready);
endinterface

interface msi_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [msi_pkg::DATA_W-1:0] prediction;
  modport source (output valid, prediction, input ready);
  modport sink (input valid, prediction, output ready);
endinterface

// ===== hw/rtl/msi_front.sv =====
// front end: accepts items, decodes the command, drops bad-slot weight loads
// depends on msi_pkg, msi_if
module msi_front (
  msi_in_if.sink            in_ch,
  input  msi_pkg::q_stat_t  q_stat,
  output msi_pkg::q_wr_t    q_wr
);
  import msi_pkg::*;

  op_t  op;
  logic keep;

  always_comb begin
    case (in_ch.command)
      CMD_PREDICT: op = OP_PREDICT;
      CMD_LOAD_W:  op = OP_LOAD_W;
      CMD_LOAD_B:  op = OP_LOAD_B;
      CMD_LOAD_OW: op = OP_LOAD_OW;
      default:     op = OP_PREDICT;
    endcase
    keep = !(op == OP_LOAD_W && in_ch.input_slot >= NUM_SLOTS);
  end

  assign in_ch.ready      = !q_stat.full;
  assign q_wr.push        = in_ch.valid && !q_stat.full && keep;
  assign q_wr.item.op     = op;
  assign q_wr.item.neuron = in_ch.neuron_index;
  assign q_wr.item.slot   = in_ch.input_slot;
  assign q_wr.item.coeff  = in_ch.coeff_value;
  assign q_wr.item.x0     = in_ch.amplitude_in;
  assign q_wr.item.x1     = in_ch.period_in;
  assign q_wr.item.x2     = in_ch.time_in;

endmodule

// ===== hw/rtl/msi_queue.sv =====
// two-entry queue of decoded items between front and back
// depends on msi_pkg
module msi_queue (
  input  logic              clk,
  input  logic              rst,
  input  msi_pkg::q_wr_t    q_wr,
  input  logic              pop,
  output msi_pkg::q_stat_t  q_stat,
  output msi_pkg::item_t    head
);
  import msi_pkg::*;

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_pop;

  assign do_pop       = pop && count != 2'd0;
  assign q_stat.full  = count == 2'd2;
  assign q_stat.empty = count == 2'd0;
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem[wr_ptr] <= q_wr.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (q_wr.push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(q_wr.push) - 2'(do_pop);
    end
  end

endmodule

// ===== hw/rtl/msi_back.sv =====
// back end: coefficient stores, shared multiply-accumulate sequencer, result register
// depends on msi_pkg, msi_if
module msi_back (
  input  logic                                clk,
  input  logic                                rst,
  input  msi_pkg::item_t                      head,
  input  msi_pkg::q_stat_t                    q_stat,
  output logic                                pop,
  input  logic [msi_pkg::NCNT_W-1:0]          active_neurons,
  input  logic signed [msi_pkg::COEFF_W-1:0]  output_bias,
  msi_out_if.source                           out_ch
);
  import msi_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_FINISH
  } state_t;

  state_t                      state;
  logic [2:0]                  phase;
  logic [NRN_W-1:0]            neuron;
  logic [NCNT_W-1:0]           n_eff;
  logic signed [COEFF_W-1:0]   wgt0 [MAX_NEURONS];
  logic signed [COEFF_W-1:0]   wgt1 [MAX_NEURONS];
  logic signed [COEFF_W-1:0]   wgt2 [MAX_NEURONS];
  logic signed [COEFF_W-1:0]   bias [MAX_NEURONS];
  logic signed [COEFF_W-1:0]   ow   [MAX_NEURONS];
  logic signed [DATA_W-1:0]    x0;
  logic signed [DATA_W-1:0]    x1;
  logic signed [DATA_W-1:0]    x2;
  logic signed [PROD_W-1:0]    prod;
  logic signed [SUM_W-1:0]     s;
  logic signed [SUM_W-1:0]     s_sum;
  logic signed [ACT_W:0]       act;
  logic signed [ACC_W-1:0]     acc;
  logic signed [COEFF_W-1:0]   mul_a;
  logic signed [DATA_W-1:0]    mul_b;
  logic signed [SUM_W-17:0]    s_sh;
  logic [15:0]                 s_clamp;
  logic [15:0]                 s_off;
  logic [SIG_IDX_W-1:0]        sig_idx;
  logic                        take;
  logic                        last;

  assign n_eff = (active_neurons > NCNT_W'(MAX_NEURONS)) ? NCNT_W'(MAX_NEURONS)
                                                         : active_neurons;
  assign take  = !q_stat.empty && state == ST_IDLE
                 && (head.op != OP_PREDICT || !out_ch.valid);
  assign pop   = take;
  assign last  = NCNT_W'(neuron) == n_eff - NCNT_W'(1);

  always_comb begin
    case (phase)
      3'd0:    begin mul_a = wgt0[neuron]; mul_b = x0; end
      3'd1:    begin mul_a = wgt1[neuron]; mul_b = x1; end
      3'd2:    begin mul_a = wgt2[neuron]; mul_b = x2; end
      default: begin mul_a = ow[neuron];   mul_b = DATA_W'(act); end
    endcase
    s_sum = s + SUM_W'(prod);
    s_sh  = s_sum[SUM_W-1:16];
    if (s_sh > 32767) begin
      s_clamp = 16'h7fff;
    end else if (s_sh < -32768) begin
      s_clamp = 16'h8000;
    end else begin
      s_clamp = s_sh[15:0];
    end
    s_off   = s_clamp ^ 16'h8000;
    sig_idx = s_off[15 -: SIG_IDX_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_NEURONS; i++) begin
        wgt0[i] <= '0;
        wgt1[i] <= '0;
        wgt2[i] <= '0;
        bias[i] <= '0;
        ow[i]   <= '0;
      end
    end else if (take) begin
      case (head.op)
        OP_LOAD_W: begin
          case (head.slot)
            2'd0:    wgt0[head.neuron] <= head.coeff;
            2'd1:    wgt1[head.neuron] <= head.coeff;
            default: wgt2[head.neuron] <= head.coeff;
          endcase
        end
        OP_LOAD_B:  bias[head.neuron] <= head.coeff;
        OP_LOAD_OW: ow[head.neuron]   <= head.coeff;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      phase        <= '0;
      neuron       <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (take && head.op == OP_PREDICT) begin
            x0     <= head.x0;
            x1     <= head.x1;
            x2     <= head.x2;
            acc    <= ACC_W'(output_bias) <<< 16;
            neuron <= '0;
            phase  <= '0;
            if (n_eff == '0) begin
              out_ch.prediction <= '0;
              out_ch.valid      <= 1'b1;
            end else begin
              state <= ST_MAC;
            end
          end
        end
        ST_MAC: begin
          case (phase)
            3'd0: begin
              prod  <= mul_a * mul_b;
              s     <= SUM_W'(bias[neuron]) <<< 16;
              phase <= 3'd1;
            end
            3'd1, 3'd2: begin
              s     <= s_sum;
              prod  <= mul_a * mul_b;
              phase <= phase + 3'd1;
            end
            3'd3: begin
              act   <= {1'b0, SIG_TABLE[sig_idx]};
              phase <= 3'd4;
            end
            3'd4: begin
              prod  <= mul_a * mul_b;
              phase <= 3'd5;
            end
            default: begin
              acc   <= acc + ACC_W'(prod);
              phase <= '0;
              if (last) begin
                state <= ST_FINISH;
              end else begin
                neuron <= neuron + NRN_W'(1);
              end
            end
          endcase
        end
        ST_FINISH: begin
          out_ch.prediction <= DATA_W'($signed(acc[ACC_W-1:12]));
          out_ch.valid      <= 1'b1;
          state             <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/mlp_sigmoid_inference_core.sv =====
// top level of the sigmoid mlp inference core: apb registers, front, queue, back
// depends on msi_pkg, msi_if, msi_front, msi_queue, msi_back
//
//  channel  | dir | handshake        | payload
//  in_ch    | in  | valid/ready      | command, neuron_index, input_slot, coeff_value,
//           |     |                  | amplitude_in, period_in, time_in
//  out_ch   | out | valid/ready      | prediction
//  apb      | in  | psel/penable     | paddr, pwdata, prdata (active_neurons, output_bias)
//
// load items are written into the coefficient stores when the back end takes them; a predict
// runs the active neurons (n, up to 16) one after another through the one shared multiplier;
// n = 0 gives a zero result without entering the multiply loop
// a two-entry queue lets the front accept items while the back is busy or a result waits;
// reset clears all coefficient stores, the apb registers and the control state at once
module mlp_sigmoid_inference_core (
  input  logic                           clk,
  input  logic                           rst,
  msi_in_if.sink                         in_ch,
  msi_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [msi_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import msi_pkg::*;

  q_wr_t                      q_wr;
  q_stat_t                    q_stat;
  item_t                      head;
  logic                       pop;
  logic [NCNT_W-1:0]          active_neurons;
  logic signed [COEFF_W-1:0]  output_bias;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BIAS) ? 32'(output_bias) : 32'(active_neurons);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_neurons <= '0;
      output_bias    <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_ACTIVE: active_neurons <= pwdata[NCNT_W-1:0];
        REG_BIAS:   output_bias    <= pwdata[COEFF_W-1:0];
        default:    ;
      endcase
    end
  end

  msi_front u_front (
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .q_wr   (q_wr)
  );

  msi_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_wr   (q_wr),
    .pop    (pop),
    .q_stat (q_stat),
    .head   (head)
  );

  msi_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .q_stat         (q_stat),
    .pop            (pop),
    .active_neurons (active_neurons),
    .output_bias    (output_bias),
    .out_ch         (out_ch)
  );

endmodule
